/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the Sobel edge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SEM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sem_pkg.sv */
// Shared types and constants of the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

    // Default line store depth, in pixels.
    localparam int MAX_WIDTH_DEF = 2048;

    // Pixel and configuration field widths.
    localparam int PIX_W    = 8;
    localparam int IMG_W_W  = 12;
    localparam int IMG_H_W  = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RGB_INPUT    = 2'd2;

    // Register reset values.
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic               RGB_RESET    = 1'b1;

    // Q16 luma weights; they add up to 65536.
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    // Squared magnitude at and above which the level saturates.
    localparam logic [20:0] SQ_SAT    = 21'd65025;
    localparam logic [7:0]  LEVEL_MAX = 8'd255;

    // Register contents as seen by the datapath.
    typedef struct packed {
        logic [IMG_W_W-1:0] image_width;
        logic [IMG_H_W-1:0] image_height;
        logic               rgb_input;
        logic               restart;
    } sem_cfg_t;

    // Status of the magnitude unit.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PIX_W-1:0] level;
    } sem_mag_res_t;

endpackage

/* hw/rtl/sem_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/sem_cfg.sv */
// APB register file holding the frame size and the input mode.
`timescale 1ns / 1ps

module sem_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sem_pkg::ADDR_W-1:0] paddr,
    input  logic [sem_pkg::DATA_W-1:0] pwdata,
    output logic [sem_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output sem_pkg::sem_cfg_t          cfg
);

    import sem_pkg::*;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic               rgb_reg;
    logic               wr_req;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_req  = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            rgb_reg    <= RGB_RESET;
        end
        else if (wr_req)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IMG_H_W-1:0];
                REG_RGB_INPUT:    rgb_reg    <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(height_reg);
            REG_RGB_INPUT:    prdata = DATA_W'(rgb_reg);
            default:          prdata = '0;
        endcase
    end

    // A write to either size register restarts the frame.
    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;
    assign cfg.rgb_input    = rgb_reg;
    assign cfg.restart      = wr_req &&
                              (reg_idx == REG_IMAGE_WIDTH || reg_idx == REG_IMAGE_HEIGHT);

endmodule

/* hw/rtl/sem_mag.sv */
// Sobel gradient sums, squared magnitude and bit-serial integer square root.
`timescale 1ns / 1ps

module sem_mag (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sem_pkg::PIX_W-1:0]   win [9],
    input  logic                        take,
    output sem_pkg::sem_mag_res_t       res
);

    import sem_pkg::*;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SQR  = 2'd1;
    localparam logic [1:0] M_ROOT = 2'd2;
    localparam logic [1:0] M_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [10:0] gx_reg, gy_reg;
    logic [10:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [10:0] ax_full, ay_full;
    logic [19:0] sq_x, sq_y;
    logic [20:0] sq_sum;
    logic [15:0] n_reg, n_next;
    logic [15:0] root_reg, root_next;
    logic [15:0] bit_reg, bit_next;
    logic [16:0] trial;

    // Weighted column and row sums; the difference wraps into 11 signed bits.
    assign gx_pos = {3'b0, win[2]} + {2'b0, win[5], 1'b0} + {3'b0, win[8]};
    assign gx_neg = {3'b0, win[0]} + {2'b0, win[3], 1'b0} + {3'b0, win[6]};
    assign gy_pos = {3'b0, win[6]} + {2'b0, win[7], 1'b0} + {3'b0, win[8]};
    assign gy_neg = {3'b0, win[0]} + {2'b0, win[1], 1'b0} + {3'b0, win[2]};

    // Absolute values, at most 1020 each, and their squares.
    assign ax_full = gx_reg[10] ? (~gx_reg + 11'd1) : gx_reg;
    assign ay_full = gy_reg[10] ? (~gy_reg + 11'd1) : gy_reg;
    assign sq_x    = ax_full[9:0] * ax_full[9:0];
    assign sq_y    = ay_full[9:0] * ay_full[9:0];
    assign sq_sum  = {1'b0, sq_x} + {1'b0, sq_y};

    // One step of the digit-by-digit root.
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_SQR;
                end
            end
            M_SQR:
            begin
                if (sq_sum >= SQ_SAT)
                begin
                    root_next  = 16'(LEVEL_MAX);
                    state_next = M_DONE;
                end
                else
                begin
                    n_next     = sq_sum[15:0];
                    root_next  = '0;
                    bit_next   = 16'h4000;
                    state_next = M_ROOT;
                end
            end
            M_ROOT:
            begin
                if ({1'b0, n_reg} >= trial)
                begin
                    n_next    = n_reg - trial[15:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 16'd1)
                begin
                    state_next = M_DONE;
                end
            end
            M_DONE:
            begin
                if (take)
                begin
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            gx_reg <= gx_pos - gx_neg;
            gy_reg <= gy_pos - gy_neg;
        end
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign res.busy  = (state_reg != M_IDLE);
    assign res.done  = (state_reg == M_DONE);
    assign res.level = root_reg[PIX_W-1:0];

endmodule

/* hw/rtl/sobel_edge_magnitude.sv */
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
// Pixels enter in raster order on the s_axis channel, one request per pixel,
// as red in tdata[7:0], green in [15:8] and blue in [23:16]. In RGB mode the
// pixel becomes Q16 luma, otherwise red is taken as gray. Each interior pixel
// (row >= 2, column >= 2) gives one request on m_axis: tdata is the gradient
// magnitude of the window centered one row up and one column left, saturated
// at 255, and tlast marks the frame's last interior pixel. Border pixels give
// nothing. Size and mode are set over APB; the user must set them only while
// the block is idle, which the block itself does not enforce. A size write
// restarts the frame. A border pixel is accepted, then its line store entry is
// read, modified and written; an interior pixel then also waits for the 8-step
// square root unit, whose root steps are skipped when the level saturates. The
// result sits in an output register, so the next pixel is taken while it waits;
// a stalled receiver holds the block only when a second result is ready. Reset
// clears counters, window and registers to their defaults; the line stores need no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Pixel input.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,   // chan_red, chan_green, chan_blue
    // Edge output.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // edge_level
    output logic                       m_axis_tlast,
    // Configuration.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sem_pkg::ADDR_W-1:0] paddr,
    input  logic [sem_pkg::DATA_W-1:0] pwdata,
    output logic [sem_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CW > IMG_W_W) ? CW : IMG_W_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RMW  = 2'd1;
    localparam logic [1:0] ST_MAG  = 2'd2;

    sem_cfg_t     cfg;
    sem_mag_res_t mag_res;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [IMG_H_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0]   win_reg [9];
    logic [PIX_W-1:0]   win_next [9];
    logic [PIX_W-1:0]   pix_reg;
    logic               last_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_level_reg;
    logic               out_last_reg;

    logic [EW-1:0]      w_ext, w_clamp;
    logic [CW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic               col_last, row_last, emit;
    logic               in_req, out_free, take, mag_start;
    logic [23:0]        y_sum;
    logic [PIX_W-1:0]   pix_in;
    logic [2*PIX_W-1:0] ram_rd, ram_wr;

    sem_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Effective frame size.
    always_comb
    begin
        w_ext = EW'(cfg.image_width);
        if (w_ext < EW'(3))
        begin
            w_clamp = EW'(3);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_clamp = EW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = w_ext;
        end
    end
    assign w_eff = CW'(w_clamp);
    assign h_eff = (cfg.image_height < IMG_H_W'(3)) ? IMG_H_W'(3) : cfg.image_height;

    assign col_last = (col_reg == w_eff - CW'(1));
    assign row_last = (row_reg == h_eff - IMG_H_W'(1));
    assign emit     = (row_reg >= IMG_H_W'(2)) && (col_reg >= CW'(2));

    // Luma from the incoming request.
    assign y_sum  = 24'(s_axis_tdata[7:0])   * 24'(LUMA_R)
                  + 24'(s_axis_tdata[15:8])  * 24'(LUMA_G)
                  + 24'(s_axis_tdata[23:16]) * 24'(LUMA_B);
    assign pix_in = cfg.rgb_input ? y_sum[23:16] : s_axis_tdata[7:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;

    // Both line stores share one entry per column: row b high, row a low.
    assign ram_wr = {ram_rd[PIX_W-1:0], pix_reg};

    sem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .clk     (clk),
        .wr_en   (state_reg == ST_RMW),
        .wr_addr (col_reg[AW-1:0]),
        .wr_data (ram_wr),
        .rd_en   (in_req),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (ram_rd)
    );

    // Window shift: row 0 two rows up, row 1 one up, row 2 current.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (state_reg == ST_RMW)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = ram_rd[2*PIX_W-1:PIX_W];
            win_next[3] = win_reg[4];
            win_next[4] = win_reg[5];
            win_next[5] = ram_rd[PIX_W-1:0];
            win_next[6] = win_reg[7];
            win_next[7] = win_reg[8];
            win_next[8] = pix_reg;
        end
    end

    assign mag_start = (state_reg == ST_RMW) && emit;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign take      = (state_reg == ST_MAG) && mag_res.done && out_free;

    sem_mag u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mag_start),
        .win   (win_next),
        .take  (take),
        .res   (mag_res)
    );

    // Sequencer and position counters.
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                state_next = emit ? ST_MAG : ST_IDLE;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_last ? '0 : row_reg + IMG_H_W'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_MAG:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Payload registers; the last flag follows its level into the output register.
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            pix_reg <= pix_in;
        end
        if (state_reg == ST_RMW)
        begin
            last_reg <= row_last && col_last;
        end
        if (take)
        begin
            out_level_reg <= mag_res.level;
            out_last_reg  <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_level_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks on the sequencer and counters.
    `SEM_ASSERT_IMP(a_col_in_range, clk, rst_n, 1'b1, col_reg < w_eff, "column out of range")
    `SEM_ASSERT_NXT(a_frame_wrap, clk, rst_n,
        state_reg == ST_RMW && !cfg.restart && row_last && col_last,
        col_reg == '0 && row_reg == '0, "frame did not wrap")
    `SEM_ASSERT_IMP(a_mag_active, clk, rst_n, state_reg == ST_MAG, mag_res.busy,
        "magnitude unit idle while awaited")
    `SEM_ASSERT_NXT(a_take_shows, clk, rst_n, take, m_axis_tvalid, "result not presented")

endmodule

/* dv/tb_sobel_edge_magnitude.sv */
// Self-checking testbench for the streaming Sobel edge magnitude block.
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;

    localparam int LINE_DEPTH   = 2048;
    localparam int DRAIN_CYCLES = 32;

    // One edge request as it leaves the block.
    typedef struct packed {
        logic [7:0] level;
        logic       last;
    } edge_res_t;

    // One row of the directed plan: a register write or a pixel.
    typedef struct {
        bit          is_write;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic [23:0] pixel;
        bit          typed;
        edge_res_t   result;
    } plan_row_t;

    typedef enum int {TEX_NOISE, TEX_FLAT, TEX_BINARY, TEX_RAMP} texture_e;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [sem_pkg::ADDR_W-1:0] paddr  = '0;
    logic [sem_pkg::DATA_W-1:0] pwdata = '0;
    logic [sem_pkg::DATA_W-1:0] prdata;
    logic        pready;

    // Shadow copy of the block's registers and pixel pipeline.
    logic [11:0] cfg_width  = sem_pkg::WIDTH_RESET;
    logic [15:0] cfg_height = sem_pkg::HEIGHT_RESET;
    logic        cfg_rgb    = sem_pkg::RGB_RESET;
    logic [7:0]  line_prev  [LINE_DEPTH];
    logic [7:0]  line_prev2 [LINE_DEPTH];
    logic [7:0]  win [9];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    edge_res_t   edge_exp_q [$];

    int          tx_gap_pct   = 0;
    int          rx_stall_pct = 0;
    logic [23:0] tex_base     = '0;
    int          tex_step     = 1;
    int          pixels_sent  = 0;
    int          results_seen = 0;
    int          reg_writes   = 0;
    int          mismatches   = 0;

    sobel_edge_magnitude u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Clamp the size registers the way the datapath does.
    function automatic int unsigned eff_width();
        if (cfg_width < 3)
            return 3;
        if (cfg_width > LINE_DEPTH)
            return LINE_DEPTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < 3) ? 3 : cfg_height;
    endfunction

    // Advance the shadow pipeline by one pixel; returns 1 when an edge request is due.
    function automatic bit predict_edge(input logic [23:0] px, output edge_res_t res);
        int unsigned ew, eh, pr, pg, pb, lum;
        logic [7:0]  gray, up1, up2;
        int          wv [9];
        int          gx, gy, sq, root, trial, i;
        bit          hit;
        ew  = eff_width();
        eh  = eff_height();
        res = '0;
        pr  = px[7:0];
        pg  = px[15:8];
        pb  = px[23:16];
        lum = (19595 * pr + 38470 * pg + 7471 * pb) >> 16;
        gray = cfg_rgb ? lum[7:0] : px[7:0];

        // Line stores: the row above and the one above that.
        up1 = line_prev[col_pos];
        up2 = line_prev2[col_pos];
        line_prev2[col_pos] = up1;
        line_prev[col_pos]  = gray;

        // Window rows are top, middle, current; new column enters on the right.
        win[0] = win[1]; win[1] = win[2]; win[2] = up2;
        win[3] = win[4]; win[4] = win[5]; win[5] = up1;
        win[6] = win[7]; win[7] = win[8]; win[8] = gray;

        hit = (row_pos >= 2) && (col_pos >= 2);
        if (hit)
        begin
            for (i = 0; i < 9; i++)
                wv[i] = int'(win[i]);
            gx = wv[2] + 2 * wv[5] + wv[8] - wv[0] - 2 * wv[3] - wv[6];
            gy = wv[6] + 2 * wv[7] + wv[8] - wv[0] - 2 * wv[1] - wv[2];
            sq = gx * gx + gy * gy;
            // Bitwise root; an 8-bit root tops out at 255, which is the saturation.
            root = 0;
            for (i = 7; i >= 0; i--)
            begin
                trial = root | (1 << i);
                if (trial * trial <= sq)
                    root = trial;
            end
            res.level = root[7:0];
            res.last  = (row_pos == eh - 1) && (col_pos == ew - 1);
        end

        col_pos++;
        if (col_pos >= ew)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= eh)
                row_pos = 0;
        end
        return hit;
    endfunction

    function automatic logic [23:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return {b, g, r};
    endfunction

    function automatic plan_row_t row_write(input logic [1:0] idx, input logic [31:0] value);
        plan_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.value    = value;
        return row;
    endfunction

    function automatic plan_row_t row_pixel(input logic [23:0] px, input bit typed = 1'b0,
                                            input logic [7:0] level = 8'd0,
                                            input logic last = 1'b0);
        plan_row_t row;
        row              = '{default: '0};
        row.pixel        = px;
        row.typed        = typed;
        row.result.level = level;
        row.result.last  = last;
        return row;
    endfunction

    // Pixel content for the random frames.
    function automatic logic [23:0] pick_pixel(input texture_e tex, input int k);
        logic [23:0] px;
        int          ch, v;
        px = '0;
        case (tex)
            TEX_FLAT:
            begin
                for (ch = 0; ch < 3; ch++)
                begin
                    v = int'(tex_base[8*ch +: 8]) + int'($urandom_range(3));
                    px[8*ch +: 8] = (v > 255) ? 8'd255 : v[7:0];
                end
            end
            TEX_BINARY:
                px = ($urandom_range(1) != 0) ? 24'hFF_FFFF : 24'h00_0000;
            TEX_RAMP:
            begin
                v  = k * tex_step + int'($urandom_range(2));
                px = {3{v[7:0]}};
            end
            default:
                px = 24'($urandom);
        endcase
        return px;
    endfunction

    function automatic void apply_idle(input idle_mode_e mode);
        case (mode)
            IDLE_SENDER:   begin tx_gap_pct = 45; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_gap_pct = 0;  rx_stall_pct = 45; end
            IDLE_BOTH:     begin tx_gap_pct = 25; rx_stall_pct = 25; end
            default:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endfunction

    // Offer one pixel request, starting at a falling edge, and log its expected result.
    task automatic send_pixel(input logic [23:0] px, input bit typed, input edge_res_t typed_res);
        edge_res_t res;
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 24'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_edge(px, res))
            edge_exp_q.push_back(typed ? typed_res : res);
        pixels_sent++;
        @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // A size write restarts the frame; stores and window are kept.
        case (idx)
            sem_pkg::REG_IMAGE_WIDTH:
            begin
                cfg_width = value[11:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            sem_pkg::REG_IMAGE_HEIGHT:
            begin
                cfg_height = value[15:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            sem_pkg::REG_RGB_INPUT:
                cfg_rgb = value[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid = 1'b0;
        while (edge_exp_q.size() != 0)
            @(negedge clk);
    endtask

    // Border pixels may still be in flight after the last result, so wait a little more.
    task automatic let_block_settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Receiver backpressure.
    always @(negedge clk)
    begin
        m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare every accepted edge request with the oldest expectation.
    always @(posedge clk)
    begin : edge_monitor
        edge_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (edge_exp_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected edge request, expected none, got level %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = edge_exp_q.pop_front();
                if (m_axis_tdata !== want.level)
                begin
                    mismatches++;
                    $display("%0t: edge_level mismatch, expected %0d, got %0d",
                             $time, want.level, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: frame_end mismatch, expected %0b, got %0b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #15_000_000;
        $display("tb_sobel_edge_magnitude NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t   plan [31];
        edge_res_t   none;
        texture_e    tex;
        int          ph, k, npix, pause_at, new_w, new_h;
        int unsigned ew, eh;

        none = '0;
        foreach (line_prev[i])
        begin
            line_prev[i]  = 8'd0;
            line_prev2[i] = 8'd0;
        end
        foreach (win[i])
            win[i] = 8'd0;

        // Directed frames: minimum size from out-of-range registers, gray then RGB.
        plan = '{
            row_write(sem_pkg::REG_IMAGE_WIDTH, 32'd0),
            row_write(sem_pkg::REG_IMAGE_HEIGHT, 32'd0),
            row_write(sem_pkg::REG_RGB_INPUT, 32'd0),
            // Gray: dark left columns, bright right column; green and blue must be ignored.
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd0, 8'd0), 1'b1, 8'd255, 1'b1),
            row_write(sem_pkg::REG_RGB_INPUT, 32'd1),
            // RGB after frame wrap: white top row over black, full vertical gradient.
            row_pixel(pack_pixel(8'd255, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd255, 8'd255)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd0), 1'b1, 8'd255, 1'b1),
            // Single saturated channels, each with its own luma weight.
            row_pixel(pack_pixel(8'd255, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd255)),
            row_pixel(pack_pixel(8'd255, 8'd0, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd255, 8'd0)),
            row_pixel(pack_pixel(8'd0, 8'd0, 8'd255))
        };

        // Single reset at the start of the run.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        apply_idle(IDLE_NONE);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                let_block_settle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end
            else
                send_pixel(plan[i].pixel, plan[i].typed, plan[i].result);
        end

        // Random small frames: whole frames plus a broken tail, cycling the idle modes.
        for (ph = 0; ph < 16; ph++)
        begin
            apply_idle(idle_mode_e'(ph % 4));
            let_block_settle();
            // Some phases keep the size and carry on mid-frame.
            if (ph % 4 != 1 || $urandom_range(1) == 0)
            begin
                new_w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
                new_h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
                write_reg(sem_pkg::REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_F000) | new_w);
                write_reg(sem_pkg::REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_0000) | new_h);
            end
            write_reg(sem_pkg::REG_RGB_INPUT, ($urandom & 32'hFFFF_FFFE) | $urandom_range(1));
            ew       = eff_width();
            eh       = eff_height();
            npix     = ew * eh * $urandom_range(3, 1) + $urandom_range(ew * eh - 1);
            pause_at = $urandom_range(npix - 1);
            tex      = texture_e'($urandom_range(3));
            tex_base = 24'($urandom);
            tex_step = $urandom_range(40, 1);
            for (k = 0; k < npix; k++)
            begin
                if (k == pause_at)
                    hold_until_drained();
                send_pixel(pick_pixel(tex, k), 1'b0, none);
            end
        end

        // Tallest frame, narrowest rows; only its start is streamed.
        apply_idle(IDLE_BOTH);
        let_block_settle();
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 32'd3);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 32'h0000_FFFF);
        write_reg(sem_pkg::REG_RGB_INPUT, 32'hFFFF_FFFF);
        for (k = 0; k < 60; k++)
            send_pixel(pick_pixel(TEX_NOISE, k), 1'b0, none);

        let_block_settle();
        $display("Streamed %0d pixels over %0d register writes: gray and RGB, widths 3 to 12,",
                 pixels_sent, reg_writes);
        $display("heights 3 to 65535, four idle modes; %0d edge results, %0d still pending.",
                 results_seen, edge_exp_q.size());
        if (mismatches == 0 && edge_exp_q.size() == 0)
            $display("tb_sobel_edge_magnitude OK");
        else
            $display("tb_sobel_edge_magnitude NOT OK");
        $finish;
    end

endmodule
